FILE: rtl/core/bvhq_pkg.sv
package bvhq_pkg;

	localparam logic [1:0] OP_LOAD_WORDS = 2'd0;
	localparam logic [1:0] OP_LOAD_BOX   = 2'd1;
	localparam logic [1:0] OP_QUERY      = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	localparam logic KIND_PAIR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] CFG_NODE_TOTAL    = 2'd0;
	localparam logic [1:0] CFG_ROOT_NODE     = 2'd1;
	localparam logic [1:0] CFG_PAIR_CAPACITY = 2'd2;

	localparam int IDX_W      = 17;
	localparam int VISIT_W    = 17;
	localparam logic [VISIT_W-1:0] VISIT_LIMIT = 17'd65536;
	localparam logic [15:0] HIT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] second;
		logic [15:0] first;
	} node_word_t;

endpackage

FILE: rtl/core/bvhq_tables.sv
module bvhq_tables
	import bvhq_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int CW = 32
) (
	input  logic                         clk,
	input  logic                         word_we,
	input  logic                         box_we,
	input  logic [$clog2(MAX_NODES)-1:0] waddr,
	input  node_word_t                   word_wdata,
	input  logic [6*CW-1:0]              box_wdata,
	input  logic                         re,
	input  logic [$clog2(MAX_NODES)-1:0] raddr,
	output node_word_t                   word_rdata,
	output logic [6*CW-1:0]              box_rdata
);

	node_word_t        word_mem [MAX_NODES];
	logic [6*CW-1:0]   box_mem  [MAX_NODES];
	node_word_t        word_rd_q;
	logic [6*CW-1:0]   box_rd_q;

	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[waddr] <= word_wdata;
		end
		if (re) begin
			word_rd_q <= word_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[waddr] <= box_wdata;
		end
		if (re) begin
			box_rd_q <= box_mem[raddr];
		end
	end

	assign word_rdata = word_rd_q;
	assign box_rdata  = box_rd_q;

endmodule

FILE: rtl/core/bvhq_stack.sv
module bvhq_stack
	import bvhq_pkg::*;
#(
	parameter int STACK_DEPTH = 128
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
	input  logic [15:0]                    wdata,
	input  logic                           re,
	input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
	output logic [15:0]                    rdata
);

	logic [15:0] mem [STACK_DEPTH];
	logic [15:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

FILE: rtl/core/bvh_aabb_overlap_query_top.sv
// channel  | handshake            | payload
// in       | in_valid / in_stall  | opcode, slot, word_first, word_second, box, query_active
// out      | out_valid / out_stall| result_kind, query_id, primitive_res, found_count, status, last
// cfg      | cfg_we               | cfg_index, cfg_data
// a load writes its table slot without leaving idle; in a query each node visit does
// one stack read, one table read and the overlap test, plus a second push per inner node
// a query with nothing to walk goes straight to its summary
// arst_n resets control state and registers (pair capacity to 63); tables and stack start undefined
// out_stall holds a pending result and pauses the walk only when a new result is due
module bvh_aabb_overlap_query_top
	import bvhq_pkg::*;
#(
	parameter int MAX_NODES   = 1024,
	parameter int STACK_DEPTH = 128,
	parameter int COORD_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [9:0]         slot,
	input  logic [15:0]        word_first,
	input  logic [15:0]        word_second,
	input  logic signed [31:0] min_x,
	input  logic signed [31:0] min_y,
	input  logic signed [31:0] min_z,
	input  logic signed [31:0] max_x,
	input  logic signed [31:0] max_y,
	input  logic signed [31:0] max_z,
	input  logic               query_active,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [9:0]         query_id,
	output logic [15:0]        primitive_res,
	output logic [15:0]        found_count,
	output logic [1:0]         status,
	output logic               last
);

	localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int AW  = $clog2(MAX_NODES);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int STW = $clog2(STACK_DEPTH + 1);
	localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_NODES);
	localparam logic [STW:0]     SDEP  = (STW + 1)'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POP   = 3'd1;
	localparam logic [2:0] S_IDX   = 3'd2;
	localparam logic [2:0] S_TEST  = 3'd3;
	localparam logic [2:0] S_PUSH2 = 3'd4;
	localparam logic [2:0] S_SUM   = 3'd5;

	logic [2:0]        state_q;
	logic [10:0]       node_total_q;
	logic [9:0]        root_node_q;
	logic [5:0]        pair_cap_q;
	logic [9:0]        qid_q;
	logic [6*CW-1:0]   qbox_q;
	logic [STW-1:0]    top_q;
	logic [VISIT_W-1:0] visits_q;
	logic [15:0]       hits_q;
	logic [1:0]        status_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [9:0]        oid_q;
	logic [15:0]       prim_q;
	logic [15:0]       cnt_q;
	logic [1:0]        ost_q;

	logic [IDX_W-1:0]  limit;
	logic              accept;
	logic              out_free;
	logic              pair_due;
	logic              issue;
	logic [6*CW-1:0]   box_in;

	logic              tbl_word_we, tbl_box_we, tbl_re;
	logic [AW-1:0]     tbl_waddr, tbl_raddr;
	node_word_t        tbl_word;
	logic [6*CW-1:0]   tbl_box;
	logic              stk_we, stk_re;
	logic [SAW-1:0]    stk_waddr, stk_raddr;
	logic [15:0]       stk_wdata, stk_rdata;
	logic              idx_ok, overlap, load_ok;

	assign limit    = ({6'd0, node_total_q} > MAX_N) ? MAX_N : {6'd0, node_total_q};
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign box_in   = {max_z[CW-1:0], max_y[CW-1:0], max_x[CW-1:0],
		min_z[CW-1:0], min_y[CW-1:0], min_x[CW-1:0]};
	assign load_ok  = ({7'd0, slot} < MAX_N);
	assign idx_ok   = ({1'b0, stk_rdata} < limit);
	assign pair_due = (state_q == S_TEST) && overlap && (tbl_word.second == 16'd0) &&
		(tbl_word.first != 16'd0) && (hits_q < {10'd0, pair_cap_q});
	assign issue    = out_free && (pair_due || (state_q == S_SUM));

	always_comb begin
		overlap = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if ($signed(tbl_box[a*CW +: CW]) > $signed(qbox_q[(a+3)*CW +: CW]) ||
				$signed(qbox_q[a*CW +: CW]) > $signed(tbl_box[(a+3)*CW +: CW])) begin
				overlap = 1'b0;
			end
		end
	end

	always_comb begin
		tbl_word_we = accept && (opcode == OP_LOAD_WORDS) && load_ok;
		tbl_box_we  = accept && (opcode == OP_LOAD_BOX) && load_ok;
		tbl_waddr   = AW'({7'd0, slot});
		tbl_re      = (state_q == S_IDX);
		tbl_raddr   = AW'({1'b0, stk_rdata});
		stk_re      = (state_q == S_POP);
		stk_raddr   = SAW'(top_q - STW'(1));
		stk_we      = 1'b0;
		stk_waddr   = SAW'(top_q);
		stk_wdata   = {6'd0, root_node_q};
		if (state_q == S_IDLE) begin
			stk_we    = accept && (opcode == OP_QUERY);
			stk_waddr = '0;
		end else if (state_q == S_TEST) begin
			stk_we    = overlap && (tbl_word.second != 16'd0) &&
				({1'b0, top_q} + (STW + 1)'(2) < SDEP) && (tbl_word.first != 16'd0);
			stk_wdata = tbl_word.first - 16'd1;
		end else if (state_q == S_PUSH2) begin
			stk_we    = 1'b1;
			stk_wdata = tbl_word.second - 16'd1;
		end
	end

	bvhq_tables #(.MAX_NODES(MAX_NODES), .CW(CW)) u_tables (
		.clk        (clk),
		.word_we    (tbl_word_we),
		.box_we     (tbl_box_we),
		.waddr      (tbl_waddr),
		.word_wdata ({word_second, word_first}),
		.box_wdata  (box_in),
		.re         (tbl_re),
		.raddr      (tbl_raddr),
		.word_rdata (tbl_word),
		.box_rdata  (tbl_box)
	);

	bvhq_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_total_q <= '0;
			root_node_q  <= '0;
			pair_cap_q   <= 6'd63;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODE_TOTAL:    node_total_q <= cfg_data;
				CFG_ROOT_NODE:     root_node_q  <= cfg_data[9:0];
				CFG_PAIR_CAPACITY: pair_cap_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			visits_q    <= '0;
			hits_q      <= '0;
			status_q    <= ST_OK;
			qid_q       <= '0;
			qbox_q      <= '0;
			kind_q      <= KIND_PAIR;
			oid_q       <= '0;
			prim_q      <= '0;
			cnt_q       <= '0;
			ost_q       <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_QUERY)) begin
						qid_q    <= slot;
						qbox_q   <= box_in;
						hits_q   <= '0;
						visits_q <= '0;
						status_q <= ST_OK;
						top_q    <= STW'(1);
						if (!query_active || (limit == '0)) begin
							state_q <= S_SUM;
						end else if ({7'd0, root_node_q} >= limit) begin
							status_q <= ST_BAD_INDEX;
							state_q  <= S_SUM;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					if (top_q == '0) begin
						state_q <= S_SUM;
					end else if (visits_q >= VISIT_LIMIT) begin
						status_q <= ST_OVERFLOW;
						state_q  <= S_SUM;
					end else begin
						visits_q <= visits_q + VISIT_W'(1);
						top_q    <= top_q - STW'(1);
						state_q  <= S_IDX;
					end
				end
				S_IDX: begin
					if (idx_ok) begin
						state_q <= S_TEST;
					end else begin
						status_q <= ST_BAD_INDEX;
						state_q  <= S_SUM;
					end
				end
				S_TEST: begin
					if (!overlap) begin
						state_q <= S_POP;
					end else if (tbl_word.second == 16'd0) begin
						if (tbl_word.first == 16'd0) begin
							state_q <= S_POP;
						end else if (hits_q < {10'd0, pair_cap_q}) begin
							if (out_free) begin
								kind_q      <= KIND_PAIR;
								oid_q       <= qid_q;
								prim_q      <= tbl_word.first - 16'd1;
								cnt_q       <= '0;
								ost_q       <= ST_OK;
								hits_q      <= hits_q + 16'd1;
								state_q     <= S_POP;
							end
						end else begin
							if (hits_q != HIT_MAX) begin
								hits_q <= hits_q + 16'd1;
							end
							state_q <= S_POP;
						end
					end else if ({1'b0, top_q} + (STW + 1)'(2) >= SDEP) begin
						status_q <= ST_OVERFLOW;
						state_q  <= S_SUM;
					end else if (tbl_word.first == 16'd0) begin
						status_q <= ST_MALFORMED;
						state_q  <= S_SUM;
					end else begin
						top_q   <= top_q + STW'(1);
						state_q <= S_PUSH2;
					end
				end
				S_PUSH2: begin
					top_q   <= top_q + STW'(1);
					state_q <= S_POP;
				end
				S_SUM: begin
					if (out_free) begin
						kind_q      <= KIND_SUMMARY;
						oid_q       <= qid_q;
						prim_q      <= '0;
						cnt_q       <= hits_q;
						ost_q       <= status_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign query_id      = oid_q;
	assign primitive_res = prim_q;
	assign found_count   = cnt_q;
	assign status        = ost_q;
	assign last          = kind_q;

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, top_q} <= SDEP)
		else $error("stack pointer past depth");
	a_pair_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_PAIR) |-> (status == ST_OK) && (found_count == '0))
		else $error("pair result with summary fields");
	a_sum_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) && out_free |=> out_valid && (result_kind == KIND_SUMMARY) &&
		(state_q == S_IDLE))
		else $error("summary not issued");
	a_pair_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEST) && out_free && overlap && (tbl_word.second == 16'd0) &&
		(tbl_word.first != 16'd0) && (hits_q < {10'd0, pair_cap_q}) |=>
		out_valid && (result_kind == KIND_PAIR))
		else $error("hit within capacity not emitted");

endmodule
